// ===== src/msls_pkg.sv =====
// Package: shared constants, configuration struct and the sine table lookup.
package msls_pkg;

    localparam int TABLE_DEPTH_DEF = 60;
    localparam int NUM_LEGS_DEF    = 10;
    localparam int MASK_W          = 11;
    localparam int MASK_LEGS       = MASK_W - 1;
    localparam int PERIOD_W        = 9;
    localparam int STRETCH_W       = 2;
    localparam int LEG_W           = 4;
    localparam int DUTY_W          = 9;
    localparam int SINE_ENTRIES    = 60;
    localparam int SINE_IDX_W      = 8;
    localparam int QUEUE_DEPTH     = 2;
    localparam int NUM_PHASES      = 4;

    localparam logic [PERIOD_W-1:0]  PERIOD_RST  = 9'd333;
    localparam logic [STRETCH_W-1:0] STRETCH_RST = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_MASK_PHASE0   = 3'd0;
    localparam logic [2:0] REG_MASK_PHASE120 = 3'd1;
    localparam logic [2:0] REG_MASK_PHASE180 = 3'd2;
    localparam logic [2:0] REG_MASK_PHASE240 = 3'd3;
    localparam logic [2:0] REG_PERIOD_TICKS  = 3'd4;
    localparam logic [2:0] REG_STRETCH_EVERY = 3'd5;

    typedef struct packed {
        logic [MASK_W-1:0]    mask_phase0;
        logic [MASK_W-1:0]    mask_phase120;
        logic [MASK_W-1:0]    mask_phase180;
        logic [MASK_W-1:0]    mask_phase240;
        logic [PERIOD_W-1:0]  period_ticks;
        logic [STRETCH_W-1:0] stretch_every;
    } t_cfg;

    typedef enum logic [0:0] {
        BK_IDLE = 1'b0,
        BK_EMIT = 1'b1
    } t_back_state;

    localparam logic [DUTY_W-1:0] SINE_ROM [SINE_ENTRIES] = '{
        9'd270, 9'd293, 9'd315, 9'd337, 9'd358, 9'd378, 9'd397, 9'd415, 9'd431, 9'd445,
        9'd457, 9'd467, 9'd475, 9'd481, 9'd485, 9'd486, 9'd485, 9'd481, 9'd475, 9'd467,
        9'd457, 9'd445, 9'd431, 9'd415, 9'd397, 9'd378, 9'd358, 9'd337, 9'd315, 9'd293,
        9'd270, 9'd247, 9'd225, 9'd203, 9'd182, 9'd162, 9'd143, 9'd125, 9'd109, 9'd95,
        9'd83,  9'd73,  9'd65,  9'd59,  9'd55,  9'd54,  9'd55,  9'd59,  9'd65,  9'd73,
        9'd83,  9'd95,  9'd109, 9'd125, 9'd143, 9'd162, 9'd182, 9'd203, 9'd225, 9'd247
    };

    // Table read with the index folded into the table's range; an 8-bit index
    // needs at most four subtractions.
    function automatic logic [DUTY_W-1:0] sine_at(input logic [SINE_IDX_W-1:0] idx);
        logic [SINE_IDX_W-1:0] v;
        v = idx;
        for (int k = 0; k < 4; k++) begin
            if (v >= SINE_IDX_W'(SINE_ENTRIES)) begin
                v = v - SINE_IDX_W'(SINE_ENTRIES);
            end
        end
        return SINE_ROM[v[5:0]];
    endfunction

endpackage

// ===== src/msls_queue.sv =====
// Short step queue between the tick front end and the leg update back end.
module msls_queue #(
    parameter int DEPTH = msls_pkg::QUEUE_DEPTH,
    parameter int W     = 6
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_push_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

// ===== src/msls_front.sv =====
// Front end: counts ticks, decides table steps and queues the phase index of each step.
module msls_front #(
    parameter int TABLE_DEPTH = msls_pkg::TABLE_DEPTH_DEF,
    parameter int PW          = $clog2(TABLE_DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  msls_pkg::t_cfg i_cfg,
    input  logic           i_tick_valid,
    input  logic           i_advance,
    output logic           o_tick_ready,
    input  logic           i_queue_full,
    output logic           o_push,
    output logic [PW-1:0]  o_push_phase
);

    localparam int CW = msls_pkg::PERIOD_W;
    localparam int SW = msls_pkg::STRETCH_W;

    logic [PW-1:0] r_phase, n_phase;
    logic [CW-1:0] r_countdown, n_countdown;
    logic [SW-1:0] r_stretch, n_stretch;
    logic          accept, step;
    logic [SW-1:0] stretch_eff;
    logic [CW-1:0] period_eff;
    logic          extra;
    logic [PW:0]   phase_inc;

    assign o_tick_ready = !i_queue_full;
    assign accept       = i_tick_valid && o_tick_ready && i_advance;
    assign step         = accept && (r_countdown == '0);
    assign o_push       = step;
    assign o_push_phase = r_phase;

    assign stretch_eff = (i_cfg.stretch_every == '0) ? SW'(1) : i_cfg.stretch_every;
    assign period_eff  = (i_cfg.period_ticks == '0) ? CW'(1) : i_cfg.period_ticks;
    assign extra       = (r_stretch >= stretch_eff);
    assign phase_inc   = {1'b0, r_phase} + (PW+1)'(1);

    always_comb begin
        n_phase     = r_phase;
        n_countdown = r_countdown;
        n_stretch   = r_stretch;
        if (accept) begin
            if (r_countdown != '0) begin
                n_countdown = r_countdown - 1'b1;
            end else begin
                n_phase     = (phase_inc == (PW+1)'(TABLE_DEPTH)) ? '0 : phase_inc[PW-1:0];
                n_stretch   = extra ? SW'(1) : r_stretch + 1'b1;
                n_countdown = period_eff - CW'(1) + CW'(extra);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_countdown <= '0;
            r_stretch   <= '0;
        end else begin
            r_phase     <= n_phase;
            r_countdown <= n_countdown;
            r_stretch   <= n_stretch;
        end
    end

endmodule

// ===== src/msls_back.sv =====
// Back end: reads the four phase duties and emits one update beat per enabled leg.
module msls_back #(
    parameter int TABLE_DEPTH = msls_pkg::TABLE_DEPTH_DEF,
    parameter int NUM_LEGS    = msls_pkg::NUM_LEGS_DEF,
    parameter int PW          = $clog2(TABLE_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  msls_pkg::t_cfg                i_cfg,
    input  logic                          i_queue_empty,
    input  logic [PW-1:0]                 i_queue_phase,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [msls_pkg::LEG_W-1:0]    o_leg_number,
    output logic [msls_pkg::DUTY_W-1:0]   o_duty,
    output logic                          o_last
);

    localparam int LW     = msls_pkg::LEG_W;
    localparam int DW     = msls_pkg::DUTY_W;
    localparam int NP     = msls_pkg::NUM_PHASES;
    localparam int OFF120 = TABLE_DEPTH / 3;
    localparam int OFF180 = TABLE_DEPTH / 2;
    localparam int OFF240 = (2 * TABLE_DEPTH) / 3;

    msls_pkg::t_back_state r_state, n_state;

    logic [DW-1:0]       r_duty [NP];
    logic [NUM_LEGS-1:0] r_pend, n_pend;
    logic [NUM_LEGS-1:0] enabled;
    logic [NUM_LEGS-1:0] sel_onehot;
    logic [LW-1:0]       sel_leg;
    logic [DW-1:0]       sel_duty;
    logic                sel_last;
    logic                slot_free, emit;
    logic                r_valid;
    logic [LW-1:0]       r_leg;
    logic [DW-1:0]       r_duty_out;
    logic                r_last;

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input int off);
        logic [PW:0] s;
        s = {1'b0, p} + (PW+1)'(off);
        if (s >= (PW+1)'(TABLE_DEPTH)) begin
            s = s - (PW+1)'(TABLE_DEPTH);
        end
        return s[PW-1:0];
    endfunction

    // Legs present in any mask; legs past the mask width are never enabled.
    always_comb begin
        enabled = '0;
        for (int k = 1; k <= NUM_LEGS; k++) begin
            if (k <= msls_pkg::MASK_LEGS) begin
                enabled[k-1] = i_cfg.mask_phase0[k] | i_cfg.mask_phase120[k]
                             | i_cfg.mask_phase180[k] | i_cfg.mask_phase240[k];
            end
        end
    end

    // Lowest pending leg; the later phase in mask order sets its duty.
    always_comb begin
        sel_onehot = '0;
        sel_leg    = '0;
        sel_duty   = '0;
        for (int k = NUM_LEGS; k >= 1; k--) begin
            if (r_pend[k-1]) begin
                sel_onehot      = '0;
                sel_onehot[k-1] = 1'b1;
                sel_leg         = LW'(k);
                sel_duty        = r_duty[0];
                if (k <= msls_pkg::MASK_LEGS) begin
                    if (i_cfg.mask_phase240[k]) begin
                        sel_duty = r_duty[3];
                    end else if (i_cfg.mask_phase180[k]) begin
                        sel_duty = r_duty[2];
                    end else if (i_cfg.mask_phase120[k]) begin
                        sel_duty = r_duty[1];
                    end
                end
            end
        end
    end

    assign sel_last  = ((r_pend & ~sel_onehot) == '0);
    assign slot_free = !r_valid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            msls_pkg::BK_IDLE: begin
                if (!i_queue_empty && (enabled != '0)) begin
                    n_state = msls_pkg::BK_EMIT;
                end
            end
            msls_pkg::BK_EMIT: begin
                if (slot_free && sel_last) begin
                    n_state = msls_pkg::BK_IDLE;
                end
            end
            default: n_state = msls_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        emit  = 1'b0;
        case (r_state)
            msls_pkg::BK_IDLE: o_pop = !i_queue_empty;
            msls_pkg::BK_EMIT: emit  = slot_free;
            default: begin
                o_pop = 1'b0;
                emit  = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_pend = r_pend;
        if (o_pop) begin
            n_pend = enabled;
        end else if (emit) begin
            n_pend = r_pend & ~sel_onehot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msls_pkg::BK_IDLE;
            r_pend  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_duty[0] <= msls_pkg::sine_at(msls_pkg::SINE_IDX_W'(i_queue_phase));
            r_duty[1] <= msls_pkg::sine_at(msls_pkg::SINE_IDX_W'(wrap_add(i_queue_phase, OFF120)));
            r_duty[2] <= msls_pkg::sine_at(msls_pkg::SINE_IDX_W'(wrap_add(i_queue_phase, OFF180)));
            r_duty[3] <= msls_pkg::sine_at(msls_pkg::SINE_IDX_W'(wrap_add(i_queue_phase, OFF240)));
        end
        if (emit) begin
            r_leg      <= sel_leg;
            r_duty_out <= sel_duty;
            r_last     <= sel_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_leg_number = r_leg;
    assign o_duty       = r_duty_out;
    assign o_last       = r_last;

    a_emit_has_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msls_pkg::BK_EMIT) |-> (r_pend != '0))
        else $error("back end in emit state with no pending leg");

    a_emit_clears_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> ($countones(r_pend) + 1 == $past($countones(r_pend))))
        else $error("an update beat did not retire exactly one leg");

    a_last_ends_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && sel_last) |=> (r_state == msls_pkg::BK_IDLE) && r_valid && r_last)
        else $error("final leg update did not close the step");

    a_leg_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_leg != '0) && (r_leg <= LW'(NUM_LEGS)))
        else $error("leg number out of range");

endmodule

// ===== src/multiphase_sine_leg_sequencer_top.sv =====
// Top level: configuration registers, tick front end, step queue and leg update back end.
//
// Multiphase sine leg sequencer. Each beat on the slave stream is one timer tick
// (tdata bit 0 set) or an idle beat (bit 0 clear, no time passes). A down-counter
// reloads with period_ticks, lengthened by one tick every stretch_every periods; the
// first tick after reset makes a step at once. On each step the block reads the sine
// table at the shared phase index plus 0, 1/3, 1/2 and 2/3 of the table depth and sends
// one beat on the master stream for every leg enabled in any phase mask, lowest leg
// first, with the later phase in mask order setting the duty; tlast marks the last
// beat of a step, and a step with no enabled leg sends nothing. Ticks are taken at one
// per clock while the two-entry step queue has room. The back end takes a step from the
// queue and reads the four duties in its idle state, then sends the enabled legs one by
// one in its emit state, stalling while the master side is not ready; it takes no new
// step until the last leg is sent, and the queue only fills when steps arrive faster
// than it drains them. Configuration registers sit on the APB port at byte addresses
// 4 * index and must be written with the block idle, which the block does not enforce.
module multiphase_sine_leg_sequencer_top #(
    parameter int TABLE_DEPTH = msls_pkg::TABLE_DEPTH_DEF,
    parameter int NUM_LEGS    = msls_pkg::NUM_LEGS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Tick stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] advance, [7:1] zero
    // Leg update stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [3:0] leg_number, [12:4] duty, [15:13] zero
    output logic        o_m_axis_tlast    // last_update
);

    localparam int PW = $clog2(TABLE_DEPTH);

    msls_pkg::t_cfg r_cfg;

    logic                          wr_en;
    logic [2:0]                    reg_idx;
    logic                          q_push, q_full, q_pop, q_empty;
    logic [PW-1:0]                 q_push_phase, q_pop_phase;
    logic [msls_pkg::LEG_W-1:0]    leg_number;
    logic [msls_pkg::DUTY_W-1:0]   duty;

    // Register file: writes land on the access cycle, reads are decoded directly.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mask_phase0   <= '0;
            r_cfg.mask_phase120 <= '0;
            r_cfg.mask_phase180 <= '0;
            r_cfg.mask_phase240 <= '0;
            r_cfg.period_ticks  <= msls_pkg::PERIOD_RST;
            r_cfg.stretch_every <= msls_pkg::STRETCH_RST;
        end else if (wr_en) begin
            case (reg_idx)
                msls_pkg::REG_MASK_PHASE0:
                    r_cfg.mask_phase0   <= pwdata[msls_pkg::MASK_W-1:0];
                msls_pkg::REG_MASK_PHASE120:
                    r_cfg.mask_phase120 <= pwdata[msls_pkg::MASK_W-1:0];
                msls_pkg::REG_MASK_PHASE180:
                    r_cfg.mask_phase180 <= pwdata[msls_pkg::MASK_W-1:0];
                msls_pkg::REG_MASK_PHASE240:
                    r_cfg.mask_phase240 <= pwdata[msls_pkg::MASK_W-1:0];
                msls_pkg::REG_PERIOD_TICKS:
                    r_cfg.period_ticks  <= pwdata[msls_pkg::PERIOD_W-1:0];
                msls_pkg::REG_STRETCH_EVERY:
                    r_cfg.stretch_every <= pwdata[msls_pkg::STRETCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            msls_pkg::REG_MASK_PHASE0:   prdata = 32'(r_cfg.mask_phase0);
            msls_pkg::REG_MASK_PHASE120: prdata = 32'(r_cfg.mask_phase120);
            msls_pkg::REG_MASK_PHASE180: prdata = 32'(r_cfg.mask_phase180);
            msls_pkg::REG_MASK_PHASE240: prdata = 32'(r_cfg.mask_phase240);
            msls_pkg::REG_PERIOD_TICKS:  prdata = 32'(r_cfg.period_ticks);
            msls_pkg::REG_STRETCH_EVERY: prdata = 32'(r_cfg.stretch_every);
            default:                     prdata = '0;
        endcase
    end

    msls_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PW          (PW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_tick_valid (i_s_axis_tvalid),
        .i_advance    (i_s_axis_tdata[0]),
        .o_tick_ready (o_s_axis_tready),
        .i_queue_full (q_full),
        .o_push       (q_push),
        .o_push_phase (q_push_phase)
    );

    msls_queue #(
        .DEPTH (msls_pkg::QUEUE_DEPTH),
        .W     (PW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_phase),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_empty     (q_empty),
        .o_pop_data  (q_pop_phase)
    );

    msls_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NUM_LEGS    (NUM_LEGS),
        .PW          (PW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_queue_empty (q_empty),
        .i_queue_phase (q_pop_phase),
        .o_pop         (q_pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_leg_number  (leg_number),
        .o_duty        (duty),
        .o_last        (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {3'b000, duty, leg_number};

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the multiphase sine leg sequencer top level.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // One leg update as it leaves the block: leg number, duty and the end-of-step flag.
    typedef struct packed {
        logic [msls_pkg::LEG_W-1:0]  leg;
        logic [msls_pkg::DUTY_W-1:0] duty;
        logic                        last;
    } t_leg_update;

    // A row of the directed table is either a register write, a tick beat or an idle beat.
    typedef enum logic [1:0] {
        ROW_CFG  = 2'd0,
        ROW_TICK = 2'd1,
        ROW_IDLE = 2'd2
    } t_stim_kind;

    typedef struct packed {
        t_stim_kind                  kind;
        logic [2:0]                  reg_idx;
        logic [msls_pkg::MASK_W-1:0] value;
        logic                        typed;
        t_leg_update                 want;
    } t_stim_row;

    localparam t_leg_update NO_UPDATE      = '0;
    localparam int          SETTLE_CYCLES  = 30;
    localparam int          HOLD_CYCLES    = 80;
    localparam int          REPORT_LIMIT   = 10;
    localparam int          RANDOM_PHASES  = 5;
    localparam int          TICKS_PER_SET  = 16;
    localparam int          PRESSURE_TICKS = 20;
    localparam int          LAST_TICKS     = 24;
    localparam logic [msls_pkg::MASK_W-1:0] ALL_LEGS = '1;

    localparam logic [2:0] MASK_REGS [msls_pkg::NUM_PHASES] = '{
        msls_pkg::REG_MASK_PHASE0, msls_pkg::REG_MASK_PHASE120,
        msls_pkg::REG_MASK_PHASE180, msls_pkg::REG_MASK_PHASE240
    };

    // Offsets of the four phases into the table: 0, 1/3, 1/2 and 2/3 of its depth.
    localparam int PHASE_OFFSET [msls_pkg::NUM_PHASES] = '{
        0, msls_pkg::TABLE_DEPTH_DEF / 3, msls_pkg::TABLE_DEPTH_DEF / 2,
        (2 * msls_pkg::TABLE_DEPTH_DEF) / 3
    };

    // Sine duties over one full turn, peak 486 at entry 15 and trough 54 at entry 45.
    localparam logic [msls_pkg::DUTY_W-1:0] SINE_DUTY [msls_pkg::SINE_ENTRIES] = '{
        9'd270, 9'd293, 9'd315, 9'd337, 9'd358, 9'd378, 9'd397, 9'd415, 9'd431, 9'd445,
        9'd457, 9'd467, 9'd475, 9'd481, 9'd485, 9'd486, 9'd485, 9'd481, 9'd475, 9'd467,
        9'd457, 9'd445, 9'd431, 9'd415, 9'd397, 9'd378, 9'd358, 9'd337, 9'd315, 9'd293,
        9'd270, 9'd247, 9'd225, 9'd203, 9'd182, 9'd162, 9'd143, 9'd125, 9'd109, 9'd95,
        9'd83,  9'd73,  9'd65,  9'd59,  9'd55,  9'd54,  9'd55,  9'd59,  9'd65,  9'd73,
        9'd83,  9'd95,  9'd109, 9'd125, 9'd143, 9'd162, 9'd182, 9'd203, 9'd225, 9'd247
    };

    // Directed table. Only the first two steps after reset carry typed results: with leg 1
    // alone on the zero degree phase and a period of one tick, they read table entries 0
    // and 1. Everything else is checked against the predictor.
    localparam int N_DIRECTED = 36;
    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{ROW_CFG,  msls_pkg::REG_MASK_PHASE0,   11'h002, 1'b0, NO_UPDATE},
        '{ROW_CFG,  msls_pkg::REG_PERIOD_TICKS,  11'd1,   1'b0, NO_UPDATE},
        '{ROW_IDLE, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b0, NO_UPDATE},
        '{ROW_TICK, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b1, '{4'd1, 9'd270, 1'b1}},
        '{ROW_TICK, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b1, '{4'd1, 9'd293, 1'b1}},
        '{ROW_TICK, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b0, NO_UPDATE},
        '{ROW_TICK, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b0, NO_UPDATE},
        '{ROW_TICK, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b0, NO_UPDATE},
        '{ROW_TICK, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b0, NO_UPDATE},
        '{ROW_CFG,  msls_pkg::REG_MASK_PHASE0,   11'h7FF, 1'b0, NO_UPDATE},
        '{ROW_CFG,  msls_pkg::REG_MASK_PHASE120, 11'h7FF, 1'b0, NO_UPDATE},
        '{ROW_CFG,  msls_pkg::REG_MASK_PHASE180, 11'h7FF, 1'b0, NO_UPDATE},
        '{ROW_CFG,  msls_pkg::REG_MASK_PHASE240, 11'h7FF, 1'b0, NO_UPDATE},
        '{ROW_TICK, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b0, NO_UPDATE},
        '{ROW_TICK, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b0, NO_UPDATE},
        '{ROW_CFG,  msls_pkg::REG_MASK_PHASE0,   11'h401, 1'b0, NO_UPDATE},
        '{ROW_CFG,  msls_pkg::REG_MASK_PHASE120, 11'h000, 1'b0, NO_UPDATE},
        '{ROW_CFG,  msls_pkg::REG_MASK_PHASE180, 11'h008, 1'b0, NO_UPDATE},
        '{ROW_CFG,  msls_pkg::REG_MASK_PHASE240, 11'h010, 1'b0, NO_UPDATE},
        '{ROW_TICK, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b0, NO_UPDATE},
        '{ROW_IDLE, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b0, NO_UPDATE},
        '{ROW_TICK, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b0, NO_UPDATE},
        '{ROW_CFG,  msls_pkg::REG_MASK_PHASE0,   11'h001, 1'b0, NO_UPDATE},
        '{ROW_CFG,  msls_pkg::REG_MASK_PHASE180, 11'h000, 1'b0, NO_UPDATE},
        '{ROW_CFG,  msls_pkg::REG_MASK_PHASE240, 11'h000, 1'b0, NO_UPDATE},
        '{ROW_TICK, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b0, NO_UPDATE},
        '{ROW_TICK, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b0, NO_UPDATE},
        '{ROW_CFG,  msls_pkg::REG_PERIOD_TICKS,  11'd0,   1'b0, NO_UPDATE},
        '{ROW_CFG,  msls_pkg::REG_STRETCH_EVERY, 11'd0,   1'b0, NO_UPDATE},
        '{ROW_CFG,  msls_pkg::REG_MASK_PHASE120, 11'h006, 1'b0, NO_UPDATE},
        '{ROW_TICK, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b0, NO_UPDATE},
        '{ROW_TICK, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b0, NO_UPDATE},
        '{ROW_TICK, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b0, NO_UPDATE},
        '{ROW_IDLE, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b0, NO_UPDATE},
        '{ROW_TICK, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b0, NO_UPDATE},
        '{ROW_TICK, msls_pkg::REG_MASK_PHASE0,   11'd0,   1'b0, NO_UPDATE}
    };

    // Every input of the block starts at a known value.
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        tick_valid = 1'b0;
    logic        tick_ready;
    logic [7:0]  tick_data  = '0;
    logic        upd_valid;
    logic        upd_ready  = 1'b0;
    logic [15:0] upd_data;
    logic        upd_last;

    // Predictor copy of the registers and of the step state.
    logic [msls_pkg::MASK_W-1:0]    phase_mask [msls_pkg::NUM_PHASES];
    logic [msls_pkg::PERIOD_W-1:0]  period_setting;
    logic [msls_pkg::STRETCH_W-1:0] stretch_setting;
    logic [5:0]                     phase_idx;
    logic [msls_pkg::PERIOD_W-1:0]  ticks_left;
    logic [msls_pkg::STRETCH_W-1:0] stretch_seen;
    t_leg_update                    step_out [msls_pkg::NUM_LEGS_DEF];

    // Leg updates still owed by the block, oldest first.
    t_leg_update legs_due [$];
    int          fail_count = 0;

    // Idling controls for the two sides, and the long hold-off request for the receiver.
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int hold_asks  = 0;
    int hold_taken = 0;
    int hold_left  = 0;
    int stall_left = 0;

    multiphase_sine_leg_sequencer_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_s_axis_tvalid (tick_valid),
        .o_s_axis_tready (tick_ready),
        .i_s_axis_tdata  (tick_data),   // [0] advance, [7:1] zero
        .o_m_axis_tvalid (upd_valid),
        .i_m_axis_tready (upd_ready),
        .o_m_axis_tdata  (upd_data),    // [3:0] leg_number, [12:4] duty, [15:13] zero
        .o_m_axis_tlast  (upd_last)     // last_update
    );

    always #5 i_clk = ~i_clk;

    // Return of the predictor to the state that the block holds after reset.
    function automatic void clear_sequencer_state();
        for (int p = 0; p < msls_pkg::NUM_PHASES; p++) begin
            phase_mask[p] = '0;
        end
        period_setting  = msls_pkg::PERIOD_RST;
        stretch_setting = msls_pkg::STRETCH_RST;
        phase_idx       = '0;
        ticks_left      = '0;
        stretch_seen    = '0;
    endfunction

    function automatic void store_setting(input logic [2:0] idx, input logic [31:0] value);
        case (idx)
            msls_pkg::REG_MASK_PHASE0:   phase_mask[0]   = value[msls_pkg::MASK_W-1:0];
            msls_pkg::REG_MASK_PHASE120: phase_mask[1]   = value[msls_pkg::MASK_W-1:0];
            msls_pkg::REG_MASK_PHASE180: phase_mask[2]   = value[msls_pkg::MASK_W-1:0];
            msls_pkg::REG_MASK_PHASE240: phase_mask[3]   = value[msls_pkg::MASK_W-1:0];
            msls_pkg::REG_PERIOD_TICKS:  period_setting  = value[msls_pkg::PERIOD_W-1:0];
            msls_pkg::REG_STRETCH_EVERY: stretch_setting = value[msls_pkg::STRETCH_W-1:0];
            default: ;
        endcase
    endfunction

    // Works out the leg updates that one accepted beat causes, fills step_out with them
    // and returns how many there are. A tick that finds the countdown above zero only
    // counts it down; a tick at zero reads the four phase duties, emits the enabled legs
    // (the later phase winning) and then moves the phase index and reloads the countdown.
    function automatic int step_leg_updates(input logic advance);
        logic [msls_pkg::DUTY_W-1:0] phase_duty [msls_pkg::NUM_PHASES];
        logic [msls_pkg::DUTY_W-1:0] duty;
        logic                        enabled;
        int                          n;
        int                          per;
        int                          every;
        int                          extra;
        n = 0;
        if (!advance) begin
            return 0;
        end
        if (ticks_left != 0) begin
            ticks_left = ticks_left - 1'b1;
            return 0;
        end
        for (int p = 0; p < msls_pkg::NUM_PHASES; p++) begin
            phase_duty[p] = SINE_DUTY[(int'(phase_idx) + PHASE_OFFSET[p])
                                      % msls_pkg::TABLE_DEPTH_DEF];
        end
        for (int leg = 1; leg <= msls_pkg::NUM_LEGS_DEF; leg++) begin
            enabled = 1'b0;
            duty    = '0;
            for (int p = 0; p < msls_pkg::NUM_PHASES; p++) begin
                if (phase_mask[p][leg]) begin
                    enabled = 1'b1;
                    duty    = phase_duty[p];
                end
            end
            if (enabled) begin
                step_out[n] = '{msls_pkg::LEG_W'(leg), duty, 1'b0};
                n++;
            end
        end
        if (n > 0) begin
            step_out[n-1].last = 1'b1;
        end
        phase_idx = 6'((int'(phase_idx) + 1) % msls_pkg::TABLE_DEPTH_DEF);
        // A zero stretch or period setting behaves as one.
        every = (stretch_setting == 0) ? 1 : int'(stretch_setting);
        if (int'(stretch_seen) >= every) begin
            extra        = 1;
            stretch_seen = 2'd1;
        end else begin
            extra        = 0;
            stretch_seen = stretch_seen + 1'b1;
        end
        per        = (period_setting == 0) ? 1 : int'(period_setting);
        ticks_left = msls_pkg::PERIOD_W'(per - 1 + extra);
        return n;
    endfunction

    // Register write over the configuration port: setup cycle, then access cycle. The
    // predictor takes the new value at the edge where the write lands.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        store_setting(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one beat on the tick stream and waits for it to be taken. Typed rows queue
    // their written-in result in place of the predictor's, though the predictor still
    // steps so that its state stays in line with the block.
    task automatic offer_beat(input logic advance, input logic typed, input t_leg_update want);
        int n;
        int gap;
        tick_valid <= 1'b1;
        tick_data  <= {7'd0, advance};
        @(posedge i_clk);
        while (!tick_ready) begin
            @(posedge i_clk);
        end
        n = step_leg_updates(advance);
        if (typed) begin
            legs_due.push_back(want);
        end else begin
            for (int k = 0; k < n; k++) begin
                legs_due.push_back(step_out[k]);
            end
        end
        // Occasional short gaps, so that the sender goes quiet at every point of a step.
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            tick_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops sending and waits for every owed update, then lets a step that emits nothing
    // work its way out of the block before the registers are touched.
    task automatic wait_until_idle();
        tick_valid <= 1'b0;
        while (legs_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Masks are empty or full one time in six each, and random otherwise.
    function automatic logic [msls_pkg::MASK_W-1:0] pick_mask();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return ALL_LEGS;
        end
        return msls_pkg::MASK_W'($urandom_range(0, 2047));
    endfunction

    task automatic offer_ticks(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            // Idle beats are mixed in but do not count towards the total.
            if ($urandom_range(0, 5) == 0) begin
                offer_beat(1'b0, 1'b0, NO_UPDATE);
            end else begin
                offer_beat(1'b1, 1'b0, NO_UPDATE);
                sent++;
            end
        end
    endtask

    // Receiver: checks each accepted update beat against the oldest owed one, then decides
    // whether to be ready in the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && upd_valid && upd_ready) begin
            if (legs_due.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("unexpected update beat: leg %0d duty %0d last %0b",
                             upd_data[3:0], upd_data[12:4], upd_last);
                end
            end else if (legs_due[0] !== t_leg_update'{upd_data[3:0], upd_data[12:4], upd_last})
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display({"update mismatch: expected leg %0d duty %0d last %0b,",
                              " got leg %0d duty %0d last %0b"},
                             legs_due[0].leg, legs_due[0].duty, legs_due[0].last,
                             upd_data[3:0], upd_data[12:4], upd_last);
                end
                void'(legs_due.pop_front());
            end else begin
                void'(legs_due.pop_front());
            end
        end
        if (hold_asks != hold_taken) begin
            hold_taken = hold_asks;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            upd_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            upd_ready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            upd_ready <= 1'b0;
        end else begin
            upd_ready <= 1'b1;
        end
    end

    // Stimulus: directed table, a back-pressure phase, random settings, then a final
    // stretch with no idling on either side.
    initial begin
        clear_sequencer_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            case (DIRECTED_ROWS[r].kind)
                ROW_CFG: begin
                    wait_until_idle();
                    apb_write(DIRECTED_ROWS[r].reg_idx, 32'(DIRECTED_ROWS[r].value));
                end
                ROW_TICK: offer_beat(1'b1, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
                default:  offer_beat(1'b0, 1'b0, NO_UPDATE);
            endcase
        end

        // Every leg on every phase with a one-tick period: each step asks for ten beats.
        // The receiver holds off for a long stretch so that the step queue fills and the
        // tick stream is stalled.
        wait_until_idle();
        for (int p = 0; p < msls_pkg::NUM_PHASES; p++) begin
            apb_write(MASK_REGS[p], 32'(ALL_LEGS));
        end
        apb_write(msls_pkg::REG_PERIOD_TICKS, 32'd1);
        apb_write(msls_pkg::REG_STRETCH_EVERY, 32'd1);
        hold_asks <= hold_asks + 1;
        offer_ticks(PRESSURE_TICKS);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_until_idle();
            tx_idle_on = (ph != 2);
            rx_idle_on <= (ph != 2);
            for (int p = 0; p < msls_pkg::NUM_PHASES; p++) begin
                apb_write(MASK_REGS[p], 32'(pick_mask()));
            end
            // Short periods keep steps frequent; the stretch setting walks all its values.
            apb_write(msls_pkg::REG_PERIOD_TICKS, 32'($urandom_range(0, 4)));
            apb_write(msls_pkg::REG_STRETCH_EVERY, 32'(ph % 4));
            offer_ticks(TICKS_PER_SET);
        end

        // Last part: every leg on phase zero, some moved to 180 degrees, other masks kept,
        // a short stretched period, back-to-back ticks and no idling on either side.
        wait_until_idle();
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        apb_write(msls_pkg::REG_MASK_PHASE0, 32'(ALL_LEGS));
        apb_write(msls_pkg::REG_MASK_PHASE180, 32'(pick_mask()));
        apb_write(msls_pkg::REG_PERIOD_TICKS, 32'd2);
        apb_write(msls_pkg::REG_STRETCH_EVERY, 32'd2);
        for (int k = 0; k < LAST_TICKS; k++) begin
            offer_beat(1'b1, 1'b0, NO_UPDATE);
        end

        wait_until_idle();
        if (fail_count == 0) begin
            $display("multiphase_sine_leg_sequencer_top test passed");
        end else begin
            $display("multiphase_sine_leg_sequencer_top test failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #2ms;
        $display("multiphase_sine_leg_sequencer_top test failed");
        $finish;
    end

endmodule
